// File: rtl/assert_macros.svh
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside of reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// property checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: rtl/drp_pkg.sv
package drp_pkg;

   localparam int DEF_MAX_MESSAGE_BYTES = 1500;

   localparam logic [15:0] TYPE_A          = 16'd1;
   localparam logic [15:0] A_RDATA_BYTES   = 16'd4;
   localparam logic [7:0]  PTR_MASK        = 8'hc0;
   localparam logic [7:0]  RCODE_MASK      = 8'h0f;
   localparam logic [7:0]  MAX_LABEL       = 8'd63;
   localparam int          HEADER_BYTES    = 12;
   localparam logic [3:0]  Q_FIXED_BYTES   = 4'd4;
   localparam logic [3:0]  A_FIXED_BYTES   = 4'd10;
   localparam logic [3:0]  ADDR_BYTES      = 4'd4;

   // header byte offsets
   localparam int HDR_ID_HI  = 0;
   localparam int HDR_ID_LO  = 1;
   localparam int HDR_FLAGS  = 3;
   localparam int HDR_QD_HI  = 4;
   localparam int HDR_QD_LO  = 5;
   localparam int HDR_AN_HI  = 6;
   localparam int HDR_AN_LO  = 7;
   localparam int HDR_LAST   = HEADER_BYTES - 1;

   // answer fixed field offsets
   localparam logic [3:0] AF_TYPE_HI = 4'd0;
   localparam logic [3:0] AF_TYPE_LO = 4'd1;
   localparam logic [3:0] AF_LEN_HI  = 4'd8;
   localparam logic [3:0] AF_LEN_LO  = 4'd9;

   // parse phases
   localparam logic [3:0] PH_HDR     = 4'd0;
   localparam logic [3:0] PH_Q_NAME  = 4'd1;
   localparam logic [3:0] PH_Q_PTR   = 4'd2;
   localparam logic [3:0] PH_Q_LABEL = 4'd3;
   localparam logic [3:0] PH_Q_FIXED = 4'd4;
   localparam logic [3:0] PH_A_NAME  = 4'd5;
   localparam logic [3:0] PH_A_PTR   = 4'd6;
   localparam logic [3:0] PH_A_LABEL = 4'd7;
   localparam logic [3:0] PH_A_FIXED = 4'd8;
   localparam logic [3:0] PH_A_RDATA = 4'd9;
   localparam logic [3:0] PH_A_ADDR  = 4'd10;
   localparam logic [3:0] PH_IDLE    = 4'd11;

   // result status codes
   localparam logic [3:0] ST_OK      = 4'd0;
   localparam logic [3:0] ST_SHORT   = 4'd1;
   localparam logic [3:0] ST_ID      = 4'd2;
   localparam logic [3:0] ST_RCODE   = 4'd3;
   localparam logic [3:0] ST_NOANS   = 4'd4;
   localparam logic [3:0] ST_BADQ    = 4'd5;
   localparam logic [3:0] ST_BADA    = 4'd6;
   localparam logic [3:0] ST_OVERRUN = 4'd7;
   localparam logic [3:0] ST_NOA     = 4'd8;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } drp_byte_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [3:0]  rcode;
      logic [31:0] address;
   } drp_result_type;

   typedef struct packed {
      logic free;
   } drp_out_state_type;

endpackage

// File: rtl/drp_input_stage.sv
module drp_input_stage
   import drp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last,
   input  drp_out_state_type out_state,
   output logic              byte_valid,
   output drp_byte_type      byte_out
);

   logic         valid_ff;
   logic         valid_in;
   drp_byte_type byte_ff;
   logic         accept;

   // a last byte needs room in the result register
   assign byte_valid = valid_ff && (!byte_ff.last || out_state.free);
   assign req_stall  = valid_ff && byte_ff.last && !out_state.free;
   assign accept     = req_valid && !req_stall;
   assign byte_out   = byte_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (byte_valid) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= '{data_byte: req_data_byte, last: req_last};
      end
   end

endmodule

// File: rtl/drp_parser.sv
module drp_parser
   import drp_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = DEF_MAX_MESSAGE_BYTES
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic [15:0]    expected_id,
   input  logic           byte_valid,
   input  drp_byte_type   byte_in,
   output logic           emit,
   output drp_result_type result
);

   localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0]       phase_ff, phase_in;
   logic [15:0]      qleft_ff, qleft_in;
   logic [15:0]      aleft_ff, aleft_in;
   logic [15:0]      skip_ff, skip_in;
   logic [15:0]      rtype_ff, rtype_in;
   logic [15:0]      rlen_ff, rlen_in;
   logic [3:0]       fidx_ff, fidx_in;
   logic [31:0]      acc_ff, acc_in;
   logic [7:0]       idhi_ff, idhi_in;
   logic [3:0]       status_ff, status_in;
   logic             found_ff, found_in;
   logic [3:0]       rcode_ff, rcode_in;

   logic [7:0]       b;
   logic             is_q;
   logic [3:0]       end_status;
   logic [15:0]      aleft_dec;
   logic [3:0]       fidx_inc;

   assign b         = byte_in.data_byte;
   assign is_q      = (phase_ff == PH_Q_NAME);
   assign aleft_dec = aleft_ff - 16'd1;
   assign fidx_inc  = fidx_ff + 4'd1;

   always_comb begin
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      qleft_in  = qleft_ff;
      aleft_in  = aleft_ff;
      skip_in   = skip_ff;
      rtype_in  = rtype_ff;
      rlen_in   = rlen_ff;
      fidx_in   = fidx_ff;
      acc_in    = acc_ff;
      idhi_in   = idhi_ff;
      status_in = status_ff;
      found_in  = found_ff;
      rcode_in  = rcode_ff;
      emit      = 1'b0;
      end_status = ST_OK;
      result    = '{status: ST_OK, rcode: 4'd0, address: 32'd0};

      if (byte_valid) begin
         if (pos_ff < POS_W'(MAX_MESSAGE_BYTES)) begin
            pos_in = pos_ff + POS_W'(1);
            unique case (phase_ff) inside
               PH_HDR: begin
                  unique case (pos_ff)
                     POS_W'(HDR_ID_HI): idhi_in = b;
                     POS_W'(HDR_ID_LO): begin
                        if ({idhi_ff, b} != expected_id) begin
                           status_in = ST_ID;
                        end
                     end
                     POS_W'(HDR_FLAGS): begin
                        rcode_in = 4'(b & RCODE_MASK);
                        if (status_ff == ST_OK && rcode_in != 4'd0) begin
                           status_in = ST_RCODE;
                        end
                     end
                     POS_W'(HDR_QD_HI): qleft_in = {b, 8'd0};
                     POS_W'(HDR_QD_LO): qleft_in = {qleft_ff[15:8], b};
                     POS_W'(HDR_AN_HI): aleft_in = {b, 8'd0};
                     POS_W'(HDR_AN_LO): begin
                        aleft_in = {aleft_ff[15:8], b};
                        if (status_ff == ST_OK && aleft_in == 16'd0) begin
                           status_in = ST_NOANS;
                        end
                     end
                     default: ;
                  endcase
                  if (pos_ff == POS_W'(HDR_LAST)) begin
                     if (status_in != ST_OK) begin
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = (qleft_in != 16'd0) ? PH_Q_NAME : PH_A_NAME;
                     end
                  end
               end
               PH_Q_NAME, PH_A_NAME: begin
                  if (b == 8'd0) begin
                     phase_in = is_q ? PH_Q_FIXED : PH_A_FIXED;
                     fidx_in  = 4'd0;
                  end else if ((b & PTR_MASK) == PTR_MASK) begin
                     phase_in = is_q ? PH_Q_PTR : PH_A_PTR;
                  end else if (b > MAX_LABEL) begin
                     status_in = is_q ? ST_BADQ : ST_BADA;
                     phase_in  = PH_IDLE;
                  end else begin
                     skip_in  = {8'd0, b};
                     phase_in = is_q ? PH_Q_LABEL : PH_A_LABEL;
                  end
               end
               PH_Q_PTR: begin
                  phase_in = PH_Q_FIXED;
                  fidx_in  = 4'd0;
               end
               PH_A_PTR: begin
                  phase_in = PH_A_FIXED;
                  fidx_in  = 4'd0;
               end
               PH_Q_LABEL, PH_A_LABEL: begin
                  skip_in = skip_ff - 16'd1;
                  if (skip_in == 16'd0) begin
                     phase_in = (phase_ff == PH_Q_LABEL) ? PH_Q_NAME : PH_A_NAME;
                  end
               end
               PH_Q_FIXED: begin
                  fidx_in = fidx_inc;
                  if (fidx_inc >= Q_FIXED_BYTES) begin
                     qleft_in = qleft_ff - 16'd1;
                     phase_in = (qleft_in != 16'd0) ? PH_Q_NAME : PH_A_NAME;
                  end
               end
               PH_A_FIXED: begin
                  if (fidx_ff == AF_TYPE_HI) begin
                     rtype_in = {b, 8'd0};
                  end else if (fidx_ff == AF_TYPE_LO) begin
                     rtype_in = {rtype_ff[15:8], b};
                  end else if (fidx_ff == AF_LEN_HI) begin
                     rlen_in = {b, 8'd0};
                  end else if (fidx_ff == AF_LEN_LO) begin
                     rlen_in = {rlen_ff[15:8], b};
                  end
                  fidx_in = fidx_inc;
                  if (fidx_inc >= A_FIXED_BYTES) begin
                     if (rtype_in == TYPE_A && rlen_in == A_RDATA_BYTES) begin
                        phase_in = PH_A_ADDR;
                        fidx_in  = 4'd0;
                        acc_in   = 32'd0;
                     end else if (rlen_in == 16'd0) begin
                        aleft_in = aleft_dec;
                        if (aleft_dec == 16'd0) begin
                           status_in = ST_NOA;
                           phase_in  = PH_IDLE;
                        end else begin
                           phase_in = PH_A_NAME;
                        end
                     end else begin
                        skip_in  = rlen_in;
                        phase_in = PH_A_RDATA;
                     end
                  end
               end
               PH_A_RDATA: begin
                  skip_in = skip_ff - 16'd1;
                  if (skip_in == 16'd0) begin
                     aleft_in = aleft_dec;
                     if (aleft_dec == 16'd0) begin
                        status_in = ST_NOA;
                        phase_in  = PH_IDLE;
                     end else begin
                        phase_in = PH_A_NAME;
                     end
                  end
               end
               PH_A_ADDR: begin
                  acc_in  = {acc_ff[23:0], b};
                  fidx_in = fidx_inc;
                  if (fidx_inc >= ADDR_BYTES) begin
                     found_in  = 1'b1;
                     status_in = ST_OK;
                     phase_in  = PH_IDLE;
                  end
               end
               default: ;
            endcase
         end

         if (byte_in.last) begin
            unique case (phase_in) inside
               PH_IDLE: end_status = status_in;
               PH_HDR:  end_status = ST_SHORT;
               PH_Q_NAME, PH_Q_PTR, PH_Q_LABEL, PH_Q_FIXED: end_status = ST_BADQ;
               PH_A_NAME, PH_A_PTR, PH_A_LABEL, PH_A_FIXED: end_status = ST_BADA;
               default: end_status = ST_OVERRUN;
            endcase
            emit   = 1'b1;
            result = '{status:  end_status,
                       rcode:   rcode_in,
                       address: (end_status == ST_OK && found_in) ? acc_in : 32'd0};
            pos_in    = '0;
            phase_in  = PH_HDR;
            qleft_in  = 16'd0;
            aleft_in  = 16'd0;
            skip_in   = 16'd0;
            rtype_in  = 16'd0;
            rlen_in   = 16'd0;
            fidx_in   = 4'd0;
            acc_in    = 32'd0;
            idhi_in   = 8'd0;
            status_in = ST_OK;
            found_in  = 1'b0;
            rcode_in  = 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         phase_ff  <= PH_HDR;
         qleft_ff  <= 16'd0;
         aleft_ff  <= 16'd0;
         skip_ff   <= 16'd0;
         rtype_ff  <= 16'd0;
         rlen_ff   <= 16'd0;
         fidx_ff   <= 4'd0;
         acc_ff    <= 32'd0;
         idhi_ff   <= 8'd0;
         status_ff <= ST_OK;
         found_ff  <= 1'b0;
         rcode_ff  <= 4'd0;
      end else begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         qleft_ff  <= qleft_in;
         aleft_ff  <= aleft_in;
         skip_ff   <= skip_in;
         rtype_ff  <= rtype_in;
         rlen_ff   <= rlen_in;
         fidx_ff   <= fidx_in;
         acc_ff    <= acc_in;
         idhi_ff   <= idhi_in;
         status_ff <= status_in;
         found_ff  <= found_in;
         rcode_ff  <= rcode_in;
      end
   end

endmodule

// File: rtl/drp_output_stage.sv
module drp_output_stage
   import drp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              emit,
   input  drp_result_type    result,
   output drp_out_state_type out_state,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [3:0]        rsp_status,
   output logic [3:0]        rsp_rcode,
   output logic [31:0]       rsp_address
);

   logic           valid_ff;
   logic           valid_in;
   drp_result_type result_ff;

   assign out_state   = '{free: !valid_ff || !rsp_stall};
   assign rsp_valid   = valid_ff;
   assign rsp_status  = result_ff.status;
   assign rsp_rcode   = result_ff.rcode;
   assign rsp_address = result_ff.address;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      if (emit) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         result_ff <= result;
      end
   end

endmodule

// File: rtl/dns_response_first_a_record_parser.sv
// dns response parser, first A record
// request channel: one message byte per request (req_data_byte), req_last on
// the final byte; valid/stall handshake, accepted when req_valid && !req_stall
// response channel: one response per message, issued for the request that
// carries req_last: status, rcode and the IPv4 address of the first A record
// csr channel: csr_expected_id written when csr_valid && csr_ready; csr_ready
// is always high, write only between messages
// response path: the last request passes the input register and the parse
// logic, and rsp_valid then rises from the output register
// throughput: one request per cycle while req_stall is low; each byte passes
// an input register and one pass of parse logic, the response sits in an
// output register; bytes beyond MAX_MESSAGE_BYTES are ignored
// receiver stall: the response holds; further bytes keep flowing until a
// second last byte waits in the input register, then req_stall rises
// reset: synchronous; clears parse state, empties both registers, sets the
// expected id to 0
module dns_response_first_a_record_parser
   import drp_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = DEF_MAX_MESSAGE_BYTES
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [3:0]  rsp_rcode,
   output logic [31:0] rsp_address,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_expected_id
);

   logic [15:0]       expected_id_ff;
   logic              byte_valid;
   drp_byte_type      byte_data;
   logic              emit;
   drp_result_type    result;
   drp_out_state_type out_state;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= 16'd0;
      end else if (csr_valid && csr_ready) begin
         expected_id_ff <= csr_expected_id;
      end
   end

   drp_input_stage u_input (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .out_state     (out_state),
      .byte_valid    (byte_valid),
      .byte_out      (byte_data)
   );

   drp_parser #(
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .expected_id (expected_id_ff),
      .byte_valid  (byte_valid),
      .byte_in     (byte_data),
      .emit        (emit),
      .result      (result)
   );

   drp_output_stage u_output (
      .clock       (clock),
      .reset       (reset),
      .emit        (emit),
      .result      (result),
      .out_state   (out_state),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_rcode   (rsp_rcode),
      .rsp_address (rsp_address)
   );

endmodule

// File: rtl/drp_checker.sv
`include "assert_macros.svh"

module drp_checker
   import drp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_status,
   input logic [31:0] rsp_address
);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `ASSERT_CLK(a_status_range, clock, reset, rsp_valid |-> rsp_status <= ST_NOA)
   `ASSERT_CLK(a_addr_only_ok, clock, reset, rsp_valid && rsp_status != ST_OK |-> rsp_address == 32'd0)
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall)

endmodule

bind dns_response_first_a_record_parser drp_checker u_drp_checker (.*);

// File: tb/dns_response_first_a_record_parser_test.sv
`timescale 1ns / 1ps
module dns_response_first_a_record_parser_test;
   import drp_pkg::*;

   class a_record_scoreboard;
      bit [15:0]      reply_id;
      int             pos;
      logic [3:0]     phase;
      bit [15:0]      questions_left;
      bit [15:0]      answers_left;
      bit [15:0]      skip_left;
      bit [15:0]      rr_type;
      bit [15:0]      rr_length;
      bit [3:0]       field_idx;
      bit [31:0]      addr_acc;
      bit [7:0]       id_hi;
      logic [3:0]     verdict;
      bit             found;
      bit [3:0]       rcode_seen;
      drp_result_type awaited_replies[$];
      int             mismatches;

      function new();
         reply_id = 16'h0000;
         mismatches = 0;
         restart_message();
      endfunction

      function void restart_message();
         pos = 0;
         phase = PH_HDR;
         questions_left = 0;
         answers_left = 0;
         skip_left = 0;
         rr_type = 0;
         rr_length = 0;
         field_idx = 0;
         addr_acc = 0;
         id_hi = 0;
         verdict = ST_OK;
         found = 0;
         rcode_seen = 0;
      endfunction

      function void settle(logic [3:0] code);
         verdict = code;
         phase = PH_IDLE;
      endfunction

      function void answer_finished();
         answers_left = answers_left - 16'd1;
         if (answers_left == 0) settle(ST_NOA);
         else phase = PH_A_NAME;
      endfunction

      function void name_byte(bit [7:0] b, bit in_q);
         if (b == 8'h00) begin
            phase = in_q ? PH_Q_FIXED : PH_A_FIXED;
            field_idx = 0;
         end else if ((b & PTR_MASK) == PTR_MASK) begin
            phase = in_q ? PH_Q_PTR : PH_A_PTR;
         end else if (b > MAX_LABEL) begin
            settle(in_q ? ST_BADQ : ST_BADA);
         end else begin
            skip_left = {8'h00, b};
            phase = in_q ? PH_Q_LABEL : PH_A_LABEL;
         end
      endfunction

      function void header_byte(bit [7:0] b);
         case (pos)
            HDR_ID_HI: id_hi = b;
            HDR_ID_LO: if ({id_hi, b} != reply_id) verdict = ST_ID;
            HDR_FLAGS: begin
               rcode_seen = b[3:0];
               if (verdict == ST_OK && rcode_seen != 0) verdict = ST_RCODE;
            end
            HDR_QD_HI: questions_left = {b, 8'h00};
            HDR_QD_LO: questions_left[7:0] = b;
            HDR_AN_HI: answers_left = {b, 8'h00};
            HDR_AN_LO: begin
               answers_left[7:0] = b;
               if (verdict == ST_OK && answers_left == 0) verdict = ST_NOANS;
            end
            default: ;
         endcase
         if (pos == HDR_LAST) begin
            if (verdict != ST_OK) phase = PH_IDLE;
            else phase = (questions_left != 0) ? PH_Q_NAME : PH_A_NAME;
         end
      endfunction

      function void parse_byte(bit [7:0] b);
         case (phase)
            PH_HDR: header_byte(b);
            PH_Q_NAME: name_byte(b, 1'b1);
            PH_A_NAME: name_byte(b, 1'b0);
            PH_Q_PTR: begin
               phase = PH_Q_FIXED;
               field_idx = 0;
            end
            PH_A_PTR: begin
               phase = PH_A_FIXED;
               field_idx = 0;
            end
            PH_Q_LABEL, PH_A_LABEL: begin
               skip_left = skip_left - 16'd1;
               if (skip_left == 0) phase = (phase == PH_Q_LABEL) ? PH_Q_NAME : PH_A_NAME;
            end
            PH_Q_FIXED: begin
               field_idx = field_idx + 4'd1;
               if (field_idx >= Q_FIXED_BYTES) begin
                  questions_left = questions_left - 16'd1;
                  phase = (questions_left != 0) ? PH_Q_NAME : PH_A_NAME;
               end
            end
            PH_A_FIXED: begin
               case (field_idx)
                  AF_TYPE_HI: rr_type = {b, 8'h00};
                  AF_TYPE_LO: rr_type[7:0] = b;
                  AF_LEN_HI: rr_length = {b, 8'h00};
                  AF_LEN_LO: rr_length[7:0] = b;
                  default: ;
               endcase
               field_idx = field_idx + 4'd1;
               if (field_idx >= A_FIXED_BYTES) begin
                  if (rr_type == TYPE_A && rr_length == A_RDATA_BYTES) begin
                     phase = PH_A_ADDR;
                     field_idx = 0;
                     addr_acc = 0;
                  end else if (rr_length == 0) begin
                     answer_finished();
                  end else begin
                     skip_left = rr_length;
                     phase = PH_A_RDATA;
                  end
               end
            end
            PH_A_RDATA: begin
               skip_left = skip_left - 16'd1;
               if (skip_left == 0) answer_finished();
            end
            PH_A_ADDR: begin
               addr_acc = {addr_acc[23:0], b};
               field_idx = field_idx + 4'd1;
               if (field_idx >= ADDR_BYTES) begin
                  found = 1;
                  settle(ST_OK);
               end
            end
            default: ;
         endcase
      endfunction

      function void note_request(bit [7:0] b, bit l);
         drp_result_type r;
         logic [3:0]     st;
         if (pos < DEF_MAX_MESSAGE_BYTES) begin
            parse_byte(b);
            pos++;
         end
         if (l) begin
            case (phase)
               PH_IDLE: st = verdict;
               PH_HDR: st = ST_SHORT;
               PH_Q_NAME, PH_Q_PTR, PH_Q_LABEL, PH_Q_FIXED: st = ST_BADQ;
               PH_A_NAME, PH_A_PTR, PH_A_LABEL, PH_A_FIXED: st = ST_BADA;
               default: st = ST_OVERRUN;
            endcase
            r.status = st;
            r.rcode = rcode_seen;
            r.address = (st == ST_OK && found) ? addr_acc : 32'h0;
            awaited_replies.push_back(r);
            restart_message();
         end
      endfunction

      task report(string field, bit [31:0] got, bit [31:0] want);
         $display("%0t: response mismatch on %s: got 0x%0h, predicted 0x%0h",
                  $realtime, field, got, want);
         mismatches++;
      endtask

      task check_response(logic [3:0] st, logic [3:0] rc, logic [31:0] ad);
         drp_result_type w;
         if (awaited_replies.size() == 0) begin
            report("unexpected response", 32'd1, 32'd0);
         end else begin
            w = awaited_replies.pop_front();
            if (st !== w.status) report("status", 32'(st), 32'(w.status));
            if (rc !== w.rcode) report("rcode", 32'(rc), 32'(w.rcode));
            if (ad !== w.address) report("address", ad, w.address);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_status;
   logic [3:0]  rsp_rcode;
   logic [31:0] rsp_address;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_expected_id = 16'h0000;

   a_record_scoreboard board = new();
   bit [7:0] msg[$];
   int send_idle_pct = 36;
   int recv_idle_pct = 70;
   int hold_left = 0;
   int replies_taken = 0;

   dns_response_first_a_record_parser u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_rcode       (rsp_rcode),
      .rsp_address     (rsp_address),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_expected_id (csr_expected_id)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            board.check_response(rsp_status, rsp_rcode, rsp_address);
            replies_taken++;
            // long hold so the parser backs up into the request side
            if (replies_taken % 30 == 15) hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   function void put16(bit [15:0] v);
      msg.push_back(v[15:8]);
      msg.push_back(v[7:0]);
   endfunction

   function void put_random(int n);
      for (int i = 0; i < n; i++) msg.push_back(8'($urandom_range(255)));
   endfunction

   function void put_header(bit [15:0] id, bit [7:0] flags_lo, bit [15:0] qd, bit [15:0] an);
      put16(id);
      msg.push_back(8'h81);
      msg.push_back(flags_lo);
      put16(qd);
      put16(an);
      put16(16'h0000);
      put16(16'h0000);
   endfunction

   function void put_rr_head(bit [15:0] rtype, bit [15:0] rlen);
      put16(rtype);
      put16(16'h0001);
      put16(16'($urandom_range(65535)));
      put16(16'($urandom_range(65535)));
      put16(rlen);
   endfunction

   function void put_a_answer(bit [31:0] addr);
      msg.push_back(PTR_MASK);
      msg.push_back(8'h0c);
      put_rr_head(TYPE_A, A_RDATA_BYTES);
      put16(addr[31:16]);
      put16(addr[15:0]);
   endfunction

   function void put_name();
      int labels;
      int len;
      if ($urandom_range(3) == 0) begin
         msg.push_back(8'(PTR_MASK | $urandom_range(63)));
         msg.push_back(8'($urandom_range(255)));
      end else begin
         labels = $urandom_range(3);
         for (int i = 0; i < labels; i++) begin
            len = ($urandom_range(15) == 0) ? $urandom_range(MAX_LABEL, 1) : $urandom_range(6, 1);
            msg.push_back(8'(len));
            put_random(len);
         end
         if ($urandom_range(3) == 0) begin
            msg.push_back(8'(PTR_MASK | $urandom_range(63)));
            msg.push_back(8'($urandom_range(255)));
         end else begin
            msg.push_back(8'h00);
         end
      end
   endfunction

   function void put_reply(bit [15:0] id);
      int        qd;
      int        an;
      int        len;
      bit [7:0]  flags_lo;
      bit [15:0] rtype;
      qd = $urandom_range(2);
      an = ($urandom_range(9) == 0) ? 0 : $urandom_range(3, 1);
      flags_lo = 8'($urandom_range(255));
      if ($urandom_range(9) != 0) flags_lo[3:0] = 4'h0;
      put_header(id, flags_lo, 16'(qd), 16'(an));
      for (int i = 0; i < qd; i++) begin
         put_name();
         put_random(4);
      end
      for (int i = 0; i < an; i++) begin
         put_name();
         case ($urandom_range(3))
            0, 1: rtype = TYPE_A;
            2: rtype = 16'd28;
            default: rtype = 16'($urandom_range(65535));
         endcase
         len = (rtype == TYPE_A && $urandom_range(4) != 0) ? 4 : $urandom_range(8);
         put_rr_head(rtype, 16'(len));
         put_random(len);
      end
   endfunction

   task send_request(input bit [7:0] b, input bit l);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(b, l);
   endtask

   task send_message(input int n);
      for (int i = 0; i < n; i++) send_request(msg[i], i == n - 1);
      msg.delete();
   endtask

   task write_expected_id(input bit [15:0] v);
      req_valid <= 1'b0;
      while (board.awaited_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_expected_id <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.reply_id = v;
      csr_valid <= 1'b0;
   endtask

   task run_random(input int target_bytes);
      int sent;
      int n;
      int mode;
      sent = 0;
      while (sent < target_bytes) begin
         mode = $urandom_range(19);
         if (mode < 2) put_random($urandom_range(40, 1));
         else put_reply(mode == 2 ? 16'($urandom_range(65535)) : board.reply_id);
         if (mode == 3) msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
         if (mode == 4) put_random($urandom_range(8, 1));
         n = msg.size();
         if (mode == 5 || mode == 6) n = $urandom_range(msg.size(), 1);
         sent += n;
         send_message(n);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // id register still at its reset value
      put_header(16'h0000, 8'h00, 16'd0, 16'd1);
      put_a_answer(32'hffffffff);
      send_message(msg.size());

      write_expected_id(16'hffff);
      msg.push_back(8'hff);
      send_message(msg.size());
      put_header(16'hffff, 8'h00, 16'd0, 16'd1);
      send_message(11);
      put_header(16'h0000, 8'h05, 16'd0, 16'd0);
      send_message(msg.size());
      put_header(16'hffff, 8'h0f, 16'd0, 16'd0);
      send_message(msg.size());
      put_header(16'hffff, 8'hf0, 16'd0, 16'd0);
      send_message(msg.size());
      put_header(16'hffff, 8'h00, 16'd1, 16'd1);
      msg.push_back(8'd64);
      put_random(3);
      send_message(msg.size());
      put_header(16'hffff, 8'h00, 16'd0, 16'd1);
      msg.push_back(8'd191);
      send_message(msg.size());
      put_header(16'hffff, 8'h00, 16'hffff, 16'd1);
      msg.push_back(8'd1);
      put_random(1);
      msg.push_back(8'h00);
      put_random(4);
      send_message(msg.size());
      put_header(16'hffff, 8'h00, 16'd1, 16'd2);
      msg.push_back(PTR_MASK);
      msg.push_back(8'h0c);
      put_random(4);
      msg.push_back(8'h00);
      put_rr_head(16'd5, 16'd2);
      put_random(2);
      send_message(msg.size());
      put_header(16'hffff, 8'h00, 16'd0, 16'd1);
      put_a_answer(32'h0a000001);
      send_message(msg.size() - 2);
      put_header(16'hffff, 8'h00, 16'd0, 16'd2);
      msg.push_back(8'd3);
      put_random(3);
      msg.push_back(8'h00);
      put_rr_head(TYPE_A, 16'd6);
      put_random(6);
      put_a_answer(32'h00000000);
      put_random(5);
      send_message(msg.size());
      put_header(16'hffff, 8'h00, 16'd0, 16'd1);
      msg.push_back(MAX_LABEL);
      put_random(63);
      msg.push_back(8'h00);
      put_rr_head(TYPE_A, 16'd0);
      send_message(msg.size());

      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 36 : (p == 1) ? 70 : 0;
         recv_idle_pct = (p == 0) ? 70 : (p == 1) ? 36 : 0;
         write_expected_id((p == 1) ? 16'($urandom_range(65535)) : 16'h0000);
         run_random(300);
      end

      req_valid <= 1'b0;
      while (board.awaited_replies.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.mismatches == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
